// ===== design/assert_macros.svh =====
// Assertion macros shared by the decoder's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

// ===== design/rlbd_pkg.sv =====
// Types and constants shared by the byte-run decoder modules.
`default_nettype none

package rlbd_pkg;

   // Decoded bytes per result word and width of the byte count.
   localparam int LANES = 4;
   localparam int CNT_W = 3;

   // Command queue between the front end and the back end.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Byte and run-length widths.
   localparam int DATA_W = 8;
   localparam int LEN_W = 8;

   // Result word: four bytes and the count, padded to whole bytes.
   localparam int RSP_TDATA_W = 40;

   // Header code that is skipped.
   localparam logic [DATA_W-1:0] NOOP_CODE = 8'h80;

   // Decoder mode, one-hot.
   typedef enum logic [2:0] {
      MODE_HEADER  = 3'b001,
      MODE_REPEAT  = 3'b010,
      MODE_LITERAL = 3'b100
   } mode_type;

   // One unit of work for the back end: a byte, how often it repeats,
   // and whether its last result closes the group.
   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              end_flag;
   } cmd_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ===== design/rlbd_front.sv =====
// Front end: accepts code bytes, tracks header state and queues commands.
`default_nettype none

module rlbd_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] code_byte
   input  wire logic                req_tlast,   // last_in
   output logic                     push,
   output rlbd_pkg::cmd_type        cmd,
   input  wire rlbd_pkg::qstat_type qstat
);
   import rlbd_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] pend_ff, pend_in;
   logic             accept;
   logic             lit_end;

   // Header bytes never need queue space, but a simple stall keeps it uniform.
   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign lit_end    = (pend_ff <= LEN_W'(1));

   // Classify the byte against the current mode.
   always_comb begin
      mode_in = mode_ff;
      pend_in = pend_ff;
      push    = 1'b0;
      cmd     = '{data: req_tdata, len: pend_ff, end_flag: 1'b1};
      if (accept) begin
         unique case (mode_ff)
            MODE_REPEAT: begin
               push    = 1'b1;
               mode_in = MODE_HEADER;
               pend_in = '0;
            end
            MODE_LITERAL: begin
               push = 1'b1;
               cmd  = '{data: req_tdata, len: LEN_W'(1), end_flag: lit_end};
               if (lit_end) begin
                  mode_in = MODE_HEADER;
                  pend_in = '0;
               end else begin
                  pend_in = pend_ff - LEN_W'(1);
               end
            end
            default: begin
               mode_in = MODE_HEADER;
               pend_in = '0;
               if (req_tdata == NOOP_CODE) begin
                  mode_in = MODE_HEADER;
               end else if (req_tdata[DATA_W-1]) begin
                  // Repeat run of 257 - code bytes.
                  mode_in = MODE_REPEAT;
                  pend_in = LEN_W'(9'd257 - {1'b0, req_tdata});
               end else begin
                  // Literal group of code + 1 bytes.
                  mode_in = MODE_LITERAL;
                  pend_in = LEN_W'(req_tdata) + LEN_W'(1);
               end
            end
         endcase
         // The final byte of a stream always returns to header state.
         if (req_tlast) begin
            mode_in = MODE_HEADER;
            pend_in = '0;
         end
      end
   end

   // Mode registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HEADER;
         pend_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rlbd_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none
`include "assert_macros.svh"

module rlbd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire rlbd_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output rlbd_pkg::cmd_type      pop_cmd,
   output rlbd_pkg::qstat_type    qstat
);
   import rlbd_pkg::*;

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (cnt_ff == '0);
   assign pop_cmd     = slot_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `ASSERT_CLK(a_cnt_bound, clock, reset, cnt_ff <= QCNT_W'(QDEPTH), "queue overfilled")
   `ASSERT_IMPL(a_pop_nonempty, clock, reset, pop, !qstat.empty, "pop from empty queue")
   `ASSERT_IMPL(a_push_room, clock, reset, push, !qstat.full || pop, "push into full queue")

endmodule

`default_nettype wire

// ===== design/rlbd_back.sv =====
// Back end: expands queued commands into result words of up to four bytes.
`default_nettype none
`include "assert_macros.svh"

module rlbd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   output logic                     pop,
   input  wire rlbd_pkg::cmd_type   cmd,
   input  wire rlbd_pkg::qstat_type qstat,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [39:0]              rsp_tdata,  // [7:0] out_byte0, [15:8] out_byte1,
                                                // [23:16] out_byte2, [31:24] out_byte3,
                                                // [34:32] byte_count, [39:35] zero
   output logic                     rsp_tlast   // group_end
);
   import rlbd_pkg::*;

   // Command being expanded.
   logic              cur_vld_ff, cur_vld_in;
   logic [DATA_W-1:0] cur_data_ff, cur_data_in;
   logic [LEN_W-1:0]  cur_left_ff, cur_left_in;
   logic              cur_end_ff, cur_end_in;

   // Output register.
   logic              out_vld_ff, out_vld_in;
   logic [DATA_W-1:0] out_byte_ff [LANES];
   logic [CNT_W-1:0]  out_cnt_ff;
   logic              out_last_ff;

   logic              emit;
   logic              last_chunk;
   logic [CNT_W-1:0]  chunk;
   logic [LEN_W-1:0]  left_next;

   // One result word per cycle whenever the output register frees up.
   assign emit       = cur_vld_ff && (!out_vld_ff || rsp_tready);
   assign last_chunk = (cur_left_ff <= LEN_W'(LANES));
   assign chunk      = last_chunk ? CNT_W'(cur_left_ff) : CNT_W'(LANES);
   assign left_next  = cur_left_ff - LEN_W'(chunk);
   assign pop        = !qstat.empty && (!cur_vld_ff || (emit && last_chunk));

   // Load the next command or count down the current one.
   always_comb begin
      cur_vld_in  = cur_vld_ff;
      cur_data_in = cur_data_ff;
      cur_left_in = cur_left_ff;
      cur_end_in  = cur_end_ff;
      if (emit) begin
         cur_left_in = left_next;
         if (last_chunk) begin
            cur_vld_in = 1'b0;
         end
      end
      if (pop) begin
         cur_vld_in  = 1'b1;
         cur_data_in = cmd.data;
         cur_left_in = cmd.len;
         cur_end_in  = cmd.end_flag;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         cur_vld_ff <= cur_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_data_ff <= cur_data_in;
      cur_left_ff <= cur_left_in;
      cur_end_ff  <= cur_end_in;
   end

   // Fill the output word; lanes past the count read as zero.
   always_ff @(posedge clock) begin
      if (emit) begin
         for (int j = 0; j < LANES; j++) begin
            out_byte_ff[j] <= (CNT_W'(j) < chunk) ? cur_data_ff : '0;
         end
         out_cnt_ff  <= chunk;
         out_last_ff <= cur_end_ff && last_chunk;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {5'b0, out_cnt_ff, out_byte_ff[3], out_byte_ff[2],
                        out_byte_ff[1], out_byte_ff[0]};

   `ASSERT_IMPL(a_cur_nonzero, clock, reset, cur_vld_ff, cur_left_ff != '0,
                "active command has no bytes left")
   `ASSERT_IMPL(a_cnt_range, clock, reset, out_vld_ff,
                out_cnt_ff != '0 && out_cnt_ff <= CNT_W'(LANES), "byte count out of range")

endmodule

`default_nettype wire

// ===== design/run_length_byte_decompressor_unit.sv =====
// Top level of the byte-run (PackBits) decoder.
//
//   Channel | Dir | Ports           | Words
//   req     | in  | req_t*          | one compressed code byte, tlast ends the stream
//   rsp     | out | rsp_t*          | up to four decoded bytes, tlast ends a group
//
// A header byte gives no result word.
// A literal byte gives one result word; a repeat byte of a run of n gives ceil(n/4)
// words (up to 32), one per cycle from the back end's expansion counter while rsp is not stalled.
// Input stalls only when the two-entry command queue is full.
// Reset is synchronous and clears the mode, queue and valid flags; no clearing pass.
`default_nettype none

module run_length_byte_decompressor_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] code_byte
   input  wire logic        req_tlast,   // last_in
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] out_byte0, [15:8] out_byte1,
                                         // [23:16] out_byte2, [31:24] out_byte3,
                                         // [34:32] byte_count, [39:35] zero
   output logic             rsp_tlast    // group_end
);
   import rlbd_pkg::*;

   logic      push;
   logic      pop;
   cmd_type   push_cmd;
   cmd_type   pop_cmd;
   qstat_type qstat;

   // Front end: header decoding.
   rlbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push       (push),
      .cmd        (push_cmd),
      .qstat      (qstat)
   );

   // Command queue.
   rlbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .qstat    (qstat)
   );

   // Back end: run expansion and output register.
   rlbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .cmd        (pop_cmd),
      .qstat      (qstat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
